### hdl/assert_macros.svh
// Assertion helpers shared by the reducer, datapath and controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Whenever the antecedent holds outside reset, the consequent must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/modexp_pkg.sv
package modexp_pkg;

    localparam int unsigned ExpBits = 63;
    localparam int unsigned ModBits = 31;
    localparam int unsigned OpdBits = 63;
    localparam int unsigned ProdBits = 62;
    localparam int unsigned RedCntBits = $clog2(OpdBits + 1);
    localparam logic [ModBits-1:0] ModulusReset = 31'd1000000007;

    // Operation codes.
    localparam logic OpPower = 1'b0;
    localparam logic OpInverse = 1'b1;

    typedef enum logic [3:0] {
        t_st_idle,
        t_st_reduce_base,
        t_st_wait_base,
        t_st_bit,
        t_st_mul_start,
        t_st_mul_wait,
        t_st_sqr_start,
        t_st_sqr_wait,
        t_st_done
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture operands
        logic red_base;   // start reducing the base
        logic red_mul;    // start reducing acc * pw
        logic red_sqr;    // start reducing pw * pw
        logic take_base;  // write reducer result to pw
        logic take_mul;   // write reducer result to acc
        logic take_sqr;   // write reducer result to pw, shift exponent
        logic skip_bit;   // shift exponent without multiply
        logic out_load;   // present the result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic red_busy;
        logic red_done;
        logic exp_bit;
        logic bits_left;
        logic out_full;
    } t_status;

endpackage

### hdl/modexp_reducer.sv
`include "assert_macros.svh"

// Restoring shift-subtract reducer: one remainder bit per cycle.
module modexp_reducer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [modexp_pkg::OpdBits-1:0]       i_value,
    input  logic [modexp_pkg::ModBits-1:0]       i_modulus,
    output logic                                 o_busy,
    output logic                                 o_done,
    output logic [modexp_pkg::ModBits-1:0]       o_rem
);
    logic [modexp_pkg::OpdBits-1:0]    r_val, n_val;
    logic [modexp_pkg::ModBits:0]      r_rem, n_rem;
    logic [modexp_pkg::RedCntBits-1:0] r_cnt, n_cnt;
    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [modexp_pkg::ModBits+1:0]    w_sh;
    logic [modexp_pkg::ModBits+1:0]    w_sub;

    // Shift in the next dividend bit and subtract when possible.
    always_comb begin
        w_sh = {r_rem, r_val[modexp_pkg::OpdBits-1]};
        w_sub = w_sh - {2'b00, i_modulus};
        n_val = r_val;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_val = i_value;
            n_rem = '0;
            n_cnt = modexp_pkg::RedCntBits'(modexp_pkg::OpdBits);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[modexp_pkg::OpdBits-2:0], 1'b0};
            if (!w_sub[modexp_pkg::ModBits+1]) begin
                n_rem = w_sub[modexp_pkg::ModBits:0];
            end else begin
                n_rem = w_sh[modexp_pkg::ModBits:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == modexp_pkg::RedCntBits'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_rem = r_rem[modexp_pkg::ModBits-1:0];

    `ASSERT_IMPL(a_done_after_busy, i_clk, i_rst_n, r_done, $past(r_busy), "done without busy")
    `ASSERT_CLK(a_no_done_busy, i_clk, i_rst_n, !(r_done && r_busy), "done while busy")
    `ASSERT_IMPL(a_rem_below_mod, i_clk, i_rst_n, r_done, r_rem < {1'b0, i_modulus}, "unreduced")
endmodule

### hdl/modexp_datapath.sv
`include "assert_macros.svh"

// Operand registers, one multiplier, the shared reducer and the output stage.
module modexp_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  modexp_pkg::t_cmd                   i_cmd,
    output modexp_pkg::t_status                o_status,
    input  logic [modexp_pkg::ModBits-1:0]     i_modulus,
    input  logic                               i_op,
    input  logic [modexp_pkg::OpdBits-1:0]     i_base,
    input  logic [modexp_pkg::OpdBits-1:0]     i_exponent,
    output logic [modexp_pkg::ModBits-1:0]     o_residue,
    output logic                               o_valid,
    input  logic                               i_ready
);
    logic [modexp_pkg::OpdBits-1:0]  r_base;
    logic [modexp_pkg::ExpBits-1:0]  r_exp;
    logic [modexp_pkg::ModBits-1:0]  r_acc;
    logic [modexp_pkg::ModBits-1:0]  r_pw;
    logic [modexp_pkg::ModBits-1:0]  r_res;
    logic                            r_zero;
    logic                            r_valid;
    logic [modexp_pkg::ProdBits-1:0] r_prod;
    logic                            r_red_go;
    logic                            r_red_base;
    logic                            w_red_cmd;
    logic                            w_red_start;
    logic [modexp_pkg::OpdBits-1:0]  w_red_in;
    logic                            w_red_busy;
    logic                            w_red_done;
    logic [modexp_pkg::ModBits-1:0]  w_red_rem;
    logic [modexp_pkg::ModBits-1:0]  w_mul_b;
    logic [modexp_pkg::ModBits-1:0]  w_mdec;

    assign w_mdec = i_modulus - modexp_pkg::ModBits'(2);
    assign w_mul_b = i_cmd.red_mul ? r_acc : r_pw;
    assign w_red_cmd = i_cmd.red_base || i_cmd.red_mul || i_cmd.red_sqr;

    // Operands, multiplier register and exponent shifter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_go <= 1'b0;
        end else begin
            r_red_go <= w_red_cmd;
        end
        if (w_red_cmd) begin
            r_red_base <= i_cmd.red_base;
        end
        if (i_cmd.load) begin
            r_base <= i_base;
            r_zero <= (i_modulus < modexp_pkg::ModBits'(2));
        end
        if (i_cmd.load) begin
            r_acc <= modexp_pkg::ModBits'(1);
        end else if (i_cmd.take_mul) begin
            r_acc <= w_red_rem;
        end
        if (i_cmd.red_mul || i_cmd.red_sqr) begin
            r_prod <= r_pw * w_mul_b;
        end
        if (i_cmd.take_base || i_cmd.take_sqr) begin
            r_pw <= w_red_rem;
        end
        if (i_cmd.load) begin
            if (i_op == modexp_pkg::OpInverse) begin
                r_exp <= modexp_pkg::ExpBits'(w_mdec);
            end else begin
                r_exp <= i_exponent[modexp_pkg::ExpBits-1:0];
            end
        end else if (i_cmd.take_sqr || i_cmd.skip_bit) begin
            r_exp <= r_exp >> 1;
        end
    end

    assign w_red_start = r_red_go;
    assign w_red_in = r_red_base ? r_base : modexp_pkg::OpdBits'(r_prod);

    modexp_reducer u_red (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_red_start),
        .i_value   (w_red_in),
        .i_modulus (i_modulus),
        .o_busy    (w_red_busy),
        .o_done    (w_red_done),
        .o_rem     (w_red_rem)
    );

    // Output register, held until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_res <= r_zero ? '0 : r_acc;
        end
    end

    assign o_status.red_busy = w_red_busy || r_red_go;
    assign o_status.red_done = w_red_done;
    assign o_status.exp_bit = r_exp[0];
    assign o_status.bits_left = (r_exp != '0);
    assign o_status.out_full = r_valid;
    assign o_residue = r_res;
    assign o_valid = r_valid;

    `ASSERT_IMPL(a_load_idle, i_clk, i_rst_n, i_cmd.load, !w_red_busy, "load while reducing")
    `ASSERT_IMPL(a_out_free, i_clk, i_rst_n, i_cmd.out_load, !(r_valid && !i_ready), "overwrite")
    `ASSERT_IMPL(a_acc_reduced, i_clk, i_rst_n, i_cmd.out_load && !r_zero, r_acc < i_modulus, "acc")
endmodule

### hdl/modexp_ctrl.sv
`include "assert_macros.svh"

// Sequencer: reduce base, then per exponent bit an optional multiply and a square.
module modexp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  modexp_pkg::t_status  i_status,
    output modexp_pkg::t_cmd     o_cmd
);
    modexp_pkg::t_state r_state, n_state;
    logic               w_take;
    logic               w_start;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            modexp_pkg::t_st_idle: begin
                if (i_in_valid) n_state = modexp_pkg::t_st_reduce_base;
            end
            modexp_pkg::t_st_reduce_base: n_state = modexp_pkg::t_st_wait_base;
            modexp_pkg::t_st_wait_base: begin
                if (i_status.red_done) n_state = modexp_pkg::t_st_bit;
            end
            modexp_pkg::t_st_bit: begin
                if (!i_status.bits_left) begin
                    n_state = modexp_pkg::t_st_done;
                end else if (i_status.exp_bit) begin
                    n_state = modexp_pkg::t_st_mul_start;
                end else begin
                    n_state = modexp_pkg::t_st_sqr_start;
                end
            end
            modexp_pkg::t_st_mul_start: n_state = modexp_pkg::t_st_mul_wait;
            modexp_pkg::t_st_mul_wait: begin
                if (i_status.red_done) n_state = modexp_pkg::t_st_sqr_start;
            end
            modexp_pkg::t_st_sqr_start: n_state = modexp_pkg::t_st_sqr_wait;
            modexp_pkg::t_st_sqr_wait: begin
                if (i_status.red_done) n_state = modexp_pkg::t_st_bit;
            end
            modexp_pkg::t_st_done: begin
                if (!i_status.out_full) n_state = modexp_pkg::t_st_idle;
            end
            default: n_state = modexp_pkg::t_st_idle;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            modexp_pkg::t_st_idle: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            modexp_pkg::t_st_reduce_base: o_cmd.red_base = 1'b1;
            modexp_pkg::t_st_wait_base: o_cmd.take_base = i_status.red_done;
            modexp_pkg::t_st_mul_start: o_cmd.red_mul = 1'b1;
            modexp_pkg::t_st_mul_wait: o_cmd.take_mul = i_status.red_done;
            modexp_pkg::t_st_sqr_start: o_cmd.red_sqr = 1'b1;
            modexp_pkg::t_st_sqr_wait: o_cmd.take_sqr = i_status.red_done;
            modexp_pkg::t_st_done: o_cmd.out_load = !i_status.out_full;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= modexp_pkg::t_st_idle;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_take = o_cmd.take_mul || o_cmd.take_sqr;
    assign w_start = o_cmd.red_mul || o_cmd.red_sqr;

    `ASSERT_IMPL(a_take_on_done, i_clk, i_rst_n, w_take, i_status.red_done, "take early")
    `ASSERT_IMPL(a_start_idle, i_clk, i_rst_n, w_start, !i_status.red_busy, "reducer busy")
    `ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_in_ready, !i_status.red_busy, "ready while busy")
endmodule

### hdl/modular_exponentiation_unit.sv
// Sequence: take in and reduce the base, then per exponent bit up to the highest set one a
// square, plus a multiply when the bit is set, then present the result.
// One item at a time; the next beat can be taken in the cycle after the result is loaded.
// The bit-serial reducer is shared by every product.
// Reset (synchronous, active low) empties the output and sets the modulus to 1000000007.
module modular_exponentiation_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [modexp_pkg::ModBits-1:0]    i_cfg_wr_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: base [62:0], exponent [125:63], zero fill [127:126]
    input  logic [127:0]                      s_axis_tdata,
    // tuser: operation [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: residue [30:0], zero fill [31]
    output logic [31:0]                       m_axis_tdata
);
    logic [modexp_pkg::ModBits-1:0] r_modulus;
    logic [modexp_pkg::ModBits-1:0] w_residue;
    modexp_pkg::t_cmd               w_cmd;
    modexp_pkg::t_status            w_status;

    // Modulus register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= modexp_pkg::ModulusReset;
        end else if (i_cfg_wr_en) begin
            r_modulus <= i_cfg_wr_data;
        end
    end

    modexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    modexp_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_modulus  (r_modulus),
        .i_op       (s_axis_tuser),
        .i_base     (s_axis_tdata[62:0]),
        .i_exponent (s_axis_tdata[125:63]),
        .o_residue  (w_residue),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, w_residue};
endmodule

### sim/modular_exponentiation_unit_tb.sv
`timescale 1ns / 1ps

module modular_exponentiation_unit_tb;

    localparam logic [62:0] OpdMax = {63{1'b1}};
    localparam int unsigned NumPhases = 6;
    localparam int unsigned ItemsPerPhase = 45;
    localparam int unsigned HoldCycles = 3000;

    // One row of the directed stimulus; the residue is typed in only where obvious.
    typedef struct {
        logic        op;
        logic [62:0] base;
        logic [62:0] exponent;
        bit          known;
        logic [30:0] residue;
    } t_power_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [modexp_pkg::ModBits-1:0]   i_cfg_wr_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [127:0]                     s_axis_tdata;
    logic                             s_axis_tuser;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [31:0]                      m_axis_tdata;

    // Residues still owed by the block, oldest first.
    logic [30:0] residue_q[$];
    logic [30:0] modulus_now;
    int          fail_cnt;
    int          tx_idle_pct;
    int          rx_stall_pct;
    bit          hold_go;

    t_power_row power_rows[18] = '{
        '{modexp_pkg::OpPower,   63'd0,          63'd0,      1'b1, 31'd1},
        '{modexp_pkg::OpPower,   63'd5,          63'd0,      1'b1, 31'd1},
        '{modexp_pkg::OpPower,   OpdMax,         63'd0,      1'b1, 31'd1},
        '{modexp_pkg::OpPower,   63'd0,          63'd5,      1'b1, 31'd0},
        '{modexp_pkg::OpPower,   63'd2,          63'd10,     1'b1, 31'd1024},
        '{modexp_pkg::OpPower,   63'd1000000007, 63'd3,      1'b1, 31'd0},
        '{modexp_pkg::OpPower,   63'd1000000008, 63'd7,      1'b1, 31'd1},
        '{modexp_pkg::OpPower,   63'd1000000006, 63'd1,      1'b1, 31'd1000000006},
        '{modexp_pkg::OpPower,   63'd1000000006, 63'd2,      1'b1, 31'd1},
        '{modexp_pkg::OpPower,   OpdMax,         63'd1,      1'b0, 31'd0},
        '{modexp_pkg::OpPower,   63'd3,          OpdMax,     1'b0, 31'd0},
        '{modexp_pkg::OpPower,   OpdMax,         OpdMax,     1'b0, 31'd0},
        '{modexp_pkg::OpPower,   63'd12345,      63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 31'd0},
        '{modexp_pkg::OpInverse, 63'd2,          63'h5555_5555_5555_5555, 1'b1, 31'd500000004},
        '{modexp_pkg::OpInverse, 63'd0,          63'd9,      1'b1, 31'd0},
        '{modexp_pkg::OpInverse, 63'd1000000007, OpdMax,     1'b1, 31'd0},
        '{modexp_pkg::OpInverse, 63'd1,          63'd0,      1'b1, 31'd1},
        '{modexp_pkg::OpInverse, OpdMax,         63'd0,      1'b0, 31'd0}
    };

    modular_exponentiation_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock: 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Right-to-left square and multiply over all exponent bits.
    function automatic logic [30:0] power_mod(logic op, logic [62:0] base,
                                              logic [62:0] exponent, logic [30:0] modulus);
        logic [63:0] acc;
        logic [63:0] pw;
        logic [63:0] mm;
        logic [62:0] ee;
        if (modulus < 31'd2) begin
            return 31'd0;
        end
        mm = {33'd0, modulus};
        ee = (op == modexp_pkg::OpInverse) ? {32'd0, modulus - 31'd2} : exponent;
        acc = 64'd1 % mm;
        pw = {1'b0, base} % mm;
        for (int i = 0; i < modexp_pkg::ExpBits; i++) begin
            if (ee[i]) begin
                acc = (acc * pw) % mm;
            end
            pw = (pw * pw) % mm;
        end
        return acc[30:0];
    endfunction

    function automatic logic [62:0] rand_operand();
        return 63'({$urandom, $urandom});
    endfunction

    // Offer one beat, with random idle cycles before it, and log its residue on accept.
    task automatic send_beat(logic op, logic [62:0] base, logic [62:0] exponent,
                             logic [30:0] residue);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, exponent, base};
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        residue_q = {residue_q, residue};
    endtask

    task automatic send_power(logic op, logic [62:0] base, logic [62:0] exponent);
        send_beat(op, base, exponent, power_mod(op, base, exponent, modulus_now));
    endtask

    // Wait until every residue is back, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (residue_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_modulus(logic [30:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        modulus_now = value;
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        bit hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_seen) begin
                hold_seen = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // Result checker: each accepted beat against the oldest expected residue.
    always @(posedge i_clk) begin
        logic [30:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (residue_q.size() == 0) begin
                $error("unexpected result beat, residue %0d", m_axis_tdata[30:0]);
                fail_cnt++;
            end else begin
                want = residue_q.pop_front();
                if (m_axis_tdata[30:0] !== want) begin
                    $error("residue: expected %0d, actual %0d", want, m_axis_tdata[30:0]);
                    fail_cnt++;
                end
            end
        end
    end

    // Main sequence: directed rows, then random phases over several moduli.
    initial begin
        logic [30:0] moduli[NumPhases];
        logic [62:0] base;
        logic [62:0] exponent;
        int          pick;
        fail_cnt = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_go = 1'b0;
        modulus_now = modexp_pkg::ModulusReset;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (power_rows[i]) begin
            if (power_rows[i].known) begin
                send_beat(power_rows[i].op, power_rows[i].base, power_rows[i].exponent,
                          power_rows[i].residue);
            end else begin
                send_power(power_rows[i].op, power_rows[i].base, power_rows[i].exponent);
            end
        end
        drain();

        // Smallest and largest modulus, a composite one, a small prime, random, reset value.
        moduli[0] = 31'd2;
        moduli[1] = 31'h7FFF_FFFF;
        moduli[2] = 31'd1000;
        moduli[3] = 31'd65537;
        moduli[4] = 31'($urandom_range(32'h7FFF_FFFF, 2));
        moduli[5] = 31'd1000000007;

        for (int p = 0; p < NumPhases; p++) begin
            write_modulus(moduli[p]);
            case (p % 4)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct = 60;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 60;
                end
                default: begin
                    tx_idle_pct = 24;
                    rx_stall_pct = 24;
                end
            endcase
            // The long receiver hold-off lands in the first phase, with the sender busy.
            if (p == 0) begin
                hold_go = 1'b1;
            end
            for (int n = 0; n < ItemsPerPhase; n++) begin
                pick = $urandom_range(99);
                case ($urandom_range(3))
                    0: base = rand_operand();
                    1: base = 63'($urandom_range(20));
                    2: base = {32'd0, moduli[p]} * 63'($urandom_range(8));
                    default: base = {31'd0, $urandom};
                endcase
                if (pick < 8) begin
                    send_power(modexp_pkg::OpPower, base, rand_operand());
                end else if (pick < 25) begin
                    send_power(modexp_pkg::OpInverse, base, rand_operand());
                end else begin
                    // Short exponents keep the run time down; bits above the mask are cleared.
                    exponent = rand_operand() & ((63'd1 << $urandom_range(12)) - 63'd1);
                    send_power(modexp_pkg::OpPower, base, exponent);
                end
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/modexp_pkg.sv
hdl/modexp_reducer.sv
hdl/modexp_datapath.sv
hdl/modexp_ctrl.sv
hdl/modular_exponentiation_unit.sv
sim/modular_exponentiation_unit_tb.sv
